// File: rtl/srpg_pkg.sv
// Shared types, widths and constants for the stepper ramp profile generator.
// No dependencies; every other file in rtl/ imports this package.
package srpg_pkg;

  localparam int DIVIDER_BITS  = 12;
  localparam int COUNT_BITS    = 24;
  localparam int RAMP_BITS     = 16;
  localparam int CFG_DATA_BITS = (RAMP_BITS > DIVIDER_BITS) ? RAMP_BITS : DIVIDER_BITS;
  localparam int CFG_IDX_BITS  = 3;

  // steps_left may dip to -1, brake point may go below zero while braking
  localparam int LEFT_BITS  = COUNT_BITS + 2;
  localparam int DONE_BITS  = COUNT_BITS + 1;
  localparam int BRAKE_BITS = COUNT_BITS + 2;
  localparam int CMP_BITS   = COUNT_BITS + 3;

  typedef logic [DIVIDER_BITS-1:0] div_t;
  typedef logic [RAMP_BITS-1:0]    ramp_t;

  localparam div_t  START_DIV_RST = div_t'(1024);
  localparam div_t  MIN_DIV_RST   = div_t'(384);
  localparam ramp_t RAMP_DIST_RST = ramp_t'(400);
  localparam div_t  RAMP_INC_RST  = div_t'(8);
  localparam div_t  CUR_DIV_RST   = div_t'(1024);
  localparam div_t  DIV_MAX       = {DIVIDER_BITS{1'b1}};

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_START_DIV = 3'd0,
    CFG_MIN_DIV   = 3'd1,
    CFG_RAMP_DIST = 3'd2,
    CFG_RAMP_INC  = 3'd3,
    CFG_REVERSE   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    div_t  start_div;
    div_t  min_div;
    ramp_t ramp_dist;
    div_t  ramp_inc;
    logic  reverse;
  } cfg_t;

  typedef struct packed {
    op_e                   op;
    logic [COUNT_BITS-1:0] step_total;
  } in_item_t;

  typedef struct packed {
    div_t divider;
    logic clock_run;
    logic dir_level;
    logic done_res;
    logic busy_res;
  } out_item_t;

endpackage

// File: rtl/srpg_cfg_regs.sv
// Configuration register file: ramp setup written through the plain write port.
// Depends on srpg_pkg.
module srpg_cfg_regs
  import srpg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output cfg_t                     cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_div <= START_DIV_RST;
      cfg_r.min_div   <= MIN_DIV_RST;
      cfg_r.ramp_dist <= RAMP_DIST_RST;
      cfg_r.ramp_inc  <= RAMP_INC_RST;
      cfg_r.reverse   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_idx))
        CFG_START_DIV: cfg_r.start_div <= cfg_wdata[DIVIDER_BITS-1:0];
        CFG_MIN_DIV:   cfg_r.min_div   <= cfg_wdata[DIVIDER_BITS-1:0];
        CFG_RAMP_DIST: cfg_r.ramp_dist <= cfg_wdata[RAMP_BITS-1:0];
        CFG_RAMP_INC:  cfg_r.ramp_inc  <= cfg_wdata[DIVIDER_BITS-1:0];
        CFG_REVERSE:   cfg_r.reverse   <= cfg_wdata[0];
        default: ;  // writes past the last register are dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/srpg_ramp_core.sv
// Move state, single-pass ramp update: one start/step item per item_fire cycle.
// Depends on srpg_pkg.
module srpg_ramp_core
  import srpg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      item_fire,
  input  in_item_t  item,
  output out_item_t res
);

  logic                         moving_r, moving_nxt;
  logic signed [LEFT_BITS-1:0]  steps_left_r, steps_left_nxt, left_dec;
  logic [DONE_BITS-1:0]         steps_done_r, steps_done_nxt, done_inc;
  logic signed [BRAKE_BITS-1:0] brake_r, brake_nxt;
  div_t                         cur_div_r, cur_div_nxt;
  logic                         dir_r, dir_nxt;
  logic                         done;

  logic signed [CMP_BITS-1:0]     left_ext, done_ext, brake_ext, dist_ext, reach;
  logic signed [DIVIDER_BITS+1:0] div_sub, min_ext;
  logic [DIVIDER_BITS:0]          div_add;
  logic                           ends, accel_zone, accel_ok, decel_ok;

  always_comb begin
    left_dec  = steps_left_r - LEFT_BITS'(1);
    done_inc  = steps_done_r + DONE_BITS'(1);
    left_ext  = CMP_BITS'(left_dec);
    done_ext  = CMP_BITS'(done_inc);
    brake_ext = CMP_BITS'(brake_r);
    dist_ext  = CMP_BITS'(cfg.ramp_dist);
    reach     = brake_ext + dist_ext;

    div_sub = $signed({2'b00, cur_div_r}) - $signed({2'b00, cfg.ramp_inc});
    min_ext = $signed({2'b00, cfg.min_div});
    div_add = {1'b0, cur_div_r} + {1'b0, cfg.ramp_inc};

    ends       = left_dec <= LEFT_BITS'(1);
    accel_zone = left_ext > reach;
    accel_ok   = (div_sub > min_ext) && (reach <= done_ext);
    decel_ok   = (cur_div_r < cfg.start_div) && (brake_ext >= left_ext);

    moving_nxt     = moving_r;
    steps_left_nxt = steps_left_r;
    steps_done_nxt = steps_done_r;
    brake_nxt      = brake_r;
    cur_div_nxt    = cur_div_r;
    dir_nxt        = dir_r;
    done           = 1'b0;

    if (item.op == OP_START) begin
      // start while busy is dropped
      if (!moving_r) begin
        moving_nxt     = 1'b1;
        steps_left_nxt = LEFT_BITS'(item.step_total);
        steps_done_nxt = '0;
        brake_nxt      = '0;
        cur_div_nxt    = cfg.start_div;
        dir_nxt        = !cfg.reverse;
      end
    end else if (moving_r) begin
      steps_done_nxt = done_inc;
      steps_left_nxt = left_dec;
      if (ends) begin
        moving_nxt = 1'b0;
        done       = 1'b1;
      end else if (accel_zone) begin
        if (accel_ok) begin
          brake_nxt   = BRAKE_BITS'(reach);
          cur_div_nxt = div_sub[DIVIDER_BITS-1:0];
        end
      end else if (decel_ok) begin
        // rise back toward the start divider, saturate at full scale
        brake_nxt   = BRAKE_BITS'(brake_ext - dist_ext);
        cur_div_nxt = div_add[DIVIDER_BITS] ? DIV_MAX : div_add[DIVIDER_BITS-1:0];
      end
    end

    res.divider   = cur_div_nxt;
    res.clock_run = moving_nxt;
    res.dir_level = dir_nxt;
    res.done_res  = done;
    res.busy_res  = moving_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      moving_r     <= 1'b0;
      steps_left_r <= '0;
      steps_done_r <= '0;
      brake_r      <= '0;
      cur_div_r    <= CUR_DIV_RST;
      dir_r        <= 1'b0;
    end else if (item_fire) begin
      moving_r     <= moving_nxt;
      steps_left_r <= steps_left_nxt;
      steps_done_r <= steps_done_nxt;
      brake_r      <= brake_nxt;
      cur_div_r    <= cur_div_nxt;
      dir_r        <= dir_nxt;
    end
  end

endmodule

// File: rtl/stepper_ramp_profile_generator_unit.sv
// Top level of the stepper ramp profile generator: input register, ramp core,
// result register and configuration registers. Depends on srpg_pkg.
//
// Usage:
//   in_*  : valid/ready channel of in_item_t. op OP_START begins a move of
//           step_total steps; op OP_STEP reports one step pulse.
//   out_* : valid/ready channel of out_item_t, exactly one result per item,
//           in order: divider to program, clock run flag, direction level,
//           move-done flag and busy flag after that item.
//   cfg_* : plain write port; cfg_idx selects start divider, min divider,
//           ramp distance, ramp increment, reverse. Write only while idle.
// Pipeline: an item transfers into the input register, and its result is
//   captured in the result register when that is free or draining.
// Throughput: one item per cycle while out_ready stays high; the whole
//   ramp update is a single pass of adds and compares between the two registers.
// Reset: synchronous rst_n clears both stages, the move state and loads the
//   default register values; no result is pending after reset.
// Stall: while out_ready is low the result holds, the input register keeps
//   its item, and in_ready drops only once both are full.
module stepper_ramp_profile_generator_unit
  import srpg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  cfg_t      cfg;
  in_item_t  item_r;
  logic      item_valid_r;
  out_item_t res;
  out_item_t out_r;
  logic      out_valid_r;
  logic      item_fire;

  srpg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // advance the input register whenever the result register is free or draining
  assign item_fire = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !item_valid_r || item_fire;

  srpg_ramp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .item_fire (item_fire),
    .item      (item_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.done_res |-> !out_r.busy_res)
    else $error("move done reported while still busy");

  a_run_tracks_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.clock_run == out_r.busy_res)
    else $error("clock run flag disagrees with busy flag");

  a_item_kept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid_r && out_valid_r && !out_ready |=> item_valid_r && $stable(item_r))
    else $error("input register lost its item during an output stall");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input accepted with both stages full");

endmodule
